// ----- rtl/ranked_list_precision_metrics_defines.svh -----
// Assertion macros used by the checker file.
`ifndef RANKED_LIST_PRECISION_METRICS_DEFINES_SVH
`define RANKED_LIST_PRECISION_METRICS_DEFINES_SVH
// An implication that must hold in the same cycle.
`define RLPM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// An implication that must hold in the next cycle.
`define RLPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
// An implication checked during reset as well.
`define RLPM_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);
`endif

// ----- rtl/rlpm_pkg.sv -----
// Shared types and constants of the ranked-list precision metrics block.
package rlpm_pkg;
  localparam int FRAC_BITS  = 16;
  localparam int VAL_W      = 17;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 2;
  localparam logic [VAL_W-1:0] ONE_FX = 17'h10000;

  localparam logic [2:0] MODE_RBP  = 3'd0;
  localparam logic [2:0] MODE_AP   = 3'd1;
  localparam logic [2:0] MODE_PAT  = 3'd2;
  localparam logic [2:0] MODE_ALL  = 3'd3;

  localparam logic [1:0] RK_POINT = 2'd0;
  localparam logic [1:0] RK_FINAL = 2'd1;
  localparam logic [1:0] RK_END   = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_CUTOFF   = 3'd1;
  localparam logic [2:0] ST_TOO_BIG  = 3'd2;
  localparam logic [2:0] ST_FRAC_BIG = 3'd3;
  localparam logic [2:0] ST_BAD_MODE = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAC  = 2'd3;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] rate;
    logic [12:0] count;
    logic [16:0] frac;
  } cfg_t;
endpackage

// ----- rtl/rlpm_if.sv -----
// Request channel interfaces for list items and results.
interface rlpm_in_if;
  logic valid;
  logic ready;
  logic is_relevant;
  logic last_in_list;
  modport source (output valid, is_relevant, last_in_list, input ready);
  modport sink (input valid, is_relevant, last_in_list, output ready);
endinterface

interface rlpm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [16:0] metric_value;
  logic [2:0]  status_code;
  logic        last_result;
  modport source (output valid, result_kind, metric_value, status_code, last_result,
                  input ready);
  modport sink (input valid, result_kind, metric_value, status_code, last_result,
                output ready);
endinterface

// ----- rtl/rlpm_queue.sv -----
// Two-entry queue between the front and back parts.
module rlpm_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         not_empty,
  output logic [W-1:0] pop_data
);
  logic [W-1:0] slots [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   fill;

  assign full      = (fill == 2'd2);
  assign not_empty = (fill != 2'd0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push && !full) wr_ptr <= ~wr_ptr;
      if (pop && not_empty) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'((push && !full) ? 1 : 0) - 2'((pop && not_empty) ? 1 : 0);
    end
  end
endmodule

// ----- rtl/rlpm_front.sv -----
// Front part: rank, positive count, rate power and RBP sum per accepted item.
module rlpm_front #(
  parameter int MAX_POSITIVES = 4096,
  parameter int RANK_BITS     = 16,
  parameter int CNT_W         = 13,
  parameter int IDX_W         = 12,
  parameter int CMD_W         = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic             is_relevant,
  input  logic             last_in_list,
  input  rlpm_pkg::cfg_t   cfg,
  output logic             push,
  output logic [CMD_W-1:0] cmd_bits
);
  import rlpm_pkg::*;

  typedef struct packed {
    logic                 store;
    logic                 last;
    logic [IDX_W-1:0]     idx;
    logic [RANK_BITS-1:0] rank;
    logic [CNT_W-1:0]     pos;
    logic                 ovf;
    logic [31:0]          sum;
  } cmd_t;

  logic [RANK_BITS-1:0] rank, rank_next;
  logic [CNT_W-1:0]     pos, pos_next;
  logic [VAL_W-1:0]     rate_power, rate_power_next;
  logic [31:0]          rbp_sum, rbp_sum_next;
  logic                 ovf, ovf_next;
  logic [32:0]          sum_wide;
  logic [32:0]          rp_prod;
  logic                 store;
  cmd_t                 cmd;

  always_comb begin
    rank_next = (&rank) ? rank : rank + 1'b1;
    sum_wide  = {1'b0, rbp_sum} + 33'(rate_power);
    store     = is_relevant && (pos < CNT_W'(MAX_POSITIVES));
    rbp_sum_next = rbp_sum;
    pos_next     = pos;
    ovf_next     = ovf;
    if (is_relevant) begin
      rbp_sum_next = sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];
      if (store) pos_next = pos + 1'b1;
      else ovf_next = 1'b1;
    end
    rp_prod         = 33'(rate_power) * 33'(cfg.rate);
    rate_power_next = rp_prod[32:16];
  end

  always_comb begin
    cmd.store = store;
    cmd.last  = last_in_list;
    cmd.idx   = pos[IDX_W-1:0];
    cmd.rank  = rank_next;
    cmd.pos   = pos_next;
    cmd.ovf   = ovf_next;
    cmd.sum   = rbp_sum_next;
  end

  assign push     = take && (store || last_in_list);
  assign cmd_bits = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      rank       <= '0;
      pos        <= '0;
      rate_power <= ONE_FX;
      rbp_sum    <= '0;
      ovf        <= 1'b0;
    end else if (take) begin
      if (last_in_list) begin
        rank       <= '0;
        pos        <= '0;
        rate_power <= ONE_FX;
        rbp_sum    <= '0;
        ovf        <= 1'b0;
      end else begin
        rank       <= rank_next;
        pos        <= pos_next;
        rate_power <= rate_power_next;
        rbp_sum    <= rbp_sum_next;
        ovf        <= ovf_next;
      end
    end
  end
endmodule

// ----- rtl/rlpm_back.sv -----
// Back part: precision divider, stores, final metrics and the output register.
module rlpm_back #(
  parameter int MAX_POSITIVES = 4096,
  parameter int RANK_BITS     = 16,
  parameter int CNT_W         = 13,
  parameter int IDX_W         = 12,
  parameter int CMD_W         = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  rlpm_pkg::cfg_t   cfg,
  input  logic             cmd_avail,
  input  logic [CMD_W-1:0] cmd_bits,
  output logic             cmd_pop,
  output logic             res_valid,
  input  logic             res_ready,
  output logic [1:0]       result_kind,
  output logic [16:0]      metric_value,
  output logic [2:0]       status_code,
  output logic             last_result
);
  import rlpm_pkg::*;

  typedef struct packed {
    logic                 store;
    logic                 last;
    logic [IDX_W-1:0]     idx;
    logic [RANK_BITS-1:0] rank;
    logic [CNT_W-1:0]     pos;
    logic                 ovf;
    logic [31:0]          sum;
  } cmd_t;

  localparam int PRE_W = VAL_W + CNT_W;
  localparam int DW    = PRE_W;
  localparam int XW    = (CNT_W + 1 > 13) ? CNT_W + 1 : 13;
  localparam int DVW   = (RANK_BITS > XW) ? RANK_BITS : XW;
  localparam int CW    = $clog2(DW);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_DDONE = 3'd2;
  localparam logic [2:0] S_FIN0  = 3'd3;
  localparam logic [2:0] S_FIN1  = 3'd4;
  localparam logic [2:0] S_RDW   = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0]       state;
  cmd_t             cmd, cmd_in;
  logic [DW-1:0]    dreg;
  logic [DVW-1:0]   dv;
  logic [DVW:0]     rem;
  logic [CW-1:0]    cnt;
  logic             div_ap;
  logic             go_fin;
  logic [PRE_W-1:0] prev_prefix;
  logic [48:0]      prod_r;
  logic [VAL_W+CNT_W-1:0] fx_r;
  logic [XW-1:0]    x_r;

  logic [VAL_W-1:0] prec_mem [MAX_POSITIVES];
  logic [PRE_W-1:0] pre_mem  [MAX_POSITIVES];
  logic [VAL_W-1:0] prec_rd;
  logic [PRE_W-1:0] pre_rd;

  logic [1:0]       k_r;
  logic [VAL_W-1:0] v_r;
  logic [2:0]       s_r;
  logic             l_r;
  logic             o_valid;

  // A result is assembled here and moves to the output register once that is free.
  logic [1:0]       pend_kind;
  logic [VAL_W-1:0] pend_value;
  logic [2:0]       pend_status;
  logic             pend_last;
  logic             emit_go;

  // Divider step and helpers.
  logic [DVW:0]     r2;
  logic             ge;
  logic [VAL_W-1:0] q_cap;
  logic [PRE_W-1:0] prefix_new;
  logic [32:0]      rbp_v;
  logic [XW-1:0]    x_frac, x_sel, x_m1;
  logic             wr_en, rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [2:0]       fin_status;

  assign cmd_in = cmd_t'(cmd_bits);
  assign r2     = {rem[DVW-1:0], dreg[DW-1]};
  assign ge     = r2 >= {1'b0, dv};
  assign q_cap  = (dreg > DW'(ONE_FX)) ? ONE_FX : dreg[VAL_W-1:0];
  assign prefix_new = ((cmd.idx == '0) ? '0 : prev_prefix) + PRE_W'(q_cap);
  assign rbp_v  = prod_r[48:16];

  always_comb begin
    x_frac = fx_r[VAL_W+CNT_W-1:16];
    if (x_frac == '0) x_frac = XW'(1);
    x_sel = (cfg.count != '0) ? XW'(cfg.count) : x_frac;
    x_m1  = x_sel - 1'b1;
    if ((cfg.count != '0) == (cfg.frac != '0)) fin_status = ST_CUTOFF;
    else if (cfg.count == '0 && cfg.frac > 17'h10000) fin_status = ST_FRAC_BIG;
    else if (cfg.count == '0 && cmd.ovf) fin_status = ST_TOO_BIG;
    else if (x_sel > XW'(cmd.pos) || x_sel > XW'(MAX_POSITIVES)) fin_status = ST_TOO_BIG;
    else fin_status = ST_OK;
  end

  assign wr_en   = (state == S_DDONE) && !div_ap;
  assign rd_en   = (state == S_FIN1);
  assign rd_addr = x_m1[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      prec_mem[cmd.idx] <= q_cap;
      pre_mem[cmd.idx]  <= prefix_new;
    end
    if (rd_en) begin
      prec_rd <= prec_mem[rd_addr];
      pre_rd  <= pre_mem[rd_addr];
    end
  end

  assign cmd_pop      = (state == S_IDLE) && cmd_avail;
  assign emit_go      = (state == S_EMIT) && (!o_valid || res_ready);
  assign res_valid    = o_valid;
  assign result_kind  = k_r;
  assign metric_value = v_r;
  assign status_code  = s_r;
  assign last_result  = l_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (emit_go) begin
      o_valid <= 1'b1;
    end else if (res_ready) begin
      o_valid <= 1'b0;
    end
    if (emit_go) begin
      k_r <= pend_kind;
      v_r <= pend_value;
      s_r <= pend_status;
      l_r <= pend_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_avail) begin
            cmd <= cmd_in;
            if (cmd_in.store) begin
              dreg   <= DW'(CNT_W'(cmd_in.idx) + 1'b1) << FRAC_BITS;
              dv     <= DVW'(cmd_in.rank);
              rem    <= '0;
              cnt    <= '0;
              div_ap <= 1'b0;
              state  <= S_DIV;
            end else begin
              state <= S_FIN0;
            end
          end
        end
        S_DIV: begin
          rem  <= ge ? r2 - {1'b0, dv} : r2;
          dreg <= {dreg[DW-2:0], ge};
          cnt  <= cnt + 1'b1;
          if (cnt == CW'(DW - 1)) state <= S_DDONE;
        end
        S_DDONE: begin
          if (div_ap) begin
            pend_kind <= RK_FINAL; pend_value <= q_cap; pend_status <= ST_OK;
            pend_last <= 1'b1;
            go_fin    <= 1'b0;
            state     <= S_EMIT;
          end else begin
            prev_prefix <= prefix_new;
            if (cfg.mode == MODE_ALL) begin
              pend_kind <= RK_POINT; pend_value <= q_cap; pend_status <= ST_OK;
              pend_last <= 1'b0;
              go_fin    <= cmd.last;
              state     <= S_EMIT;
            end else begin
              go_fin <= 1'b0;
              state  <= cmd.last ? S_FIN0 : S_IDLE;
            end
          end
        end
        S_FIN0: begin
          prod_r <= {17'b0, cmd.sum} * {32'b0, 17'h10000 - {1'b0, cfg.rate}};
          fx_r   <= (VAL_W+CNT_W)'(cfg.frac) * (VAL_W+CNT_W)'(cmd.pos);
          state  <= S_FIN1;
        end
        S_FIN1: begin
          go_fin <= 1'b0;
          if (cfg.mode == MODE_RBP) begin
            pend_kind   <= RK_FINAL;
            pend_value  <= (rbp_v > 33'(ONE_FX)) ? ONE_FX : rbp_v[VAL_W-1:0];
            pend_status <= ST_OK;
            pend_last   <= 1'b1;
            state       <= S_EMIT;
          end else if (cfg.mode == MODE_AP || cfg.mode == MODE_PAT) begin
            if (fin_status != ST_OK) begin
              pend_kind <= RK_FINAL; pend_value <= '0; pend_status <= fin_status;
              pend_last <= 1'b1;
              state     <= S_EMIT;
            end else begin
              x_r   <= x_sel;
              state <= S_RDW;
            end
          end else if (cfg.mode == MODE_ALL) begin
            pend_kind <= RK_END; pend_value <= '0; pend_status <= ST_OK;
            pend_last <= 1'b1;
            state     <= S_EMIT;
          end else begin
            pend_kind <= RK_FINAL; pend_value <= '0; pend_status <= ST_BAD_MODE;
            pend_last <= 1'b1;
            state     <= S_EMIT;
          end
        end
        S_RDW: begin
          if (cfg.mode == MODE_PAT) begin
            pend_kind <= RK_FINAL; pend_value <= prec_rd; pend_status <= ST_OK;
            pend_last <= 1'b1;
            state     <= S_EMIT;
          end else begin
            dreg   <= DW'(pre_rd);
            dv     <= DVW'(x_r);
            rem    <= '0;
            cnt    <= '0;
            div_ap <= 1'b1;
            state  <= S_DIV;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            state <= go_fin ? S_FIN0 : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/ranked_list_precision_metrics.sv -----
// A relevant item passes through the back part's bit-serial divider (PRE_W steps plus
// setup); a list end then passes through S_FIN0 and S_FIN1, and average precision adds
// another divide. The front takes one item per cycle while its two-entry queue has room,
// which the back part drains only when idle; items neither relevant nor last are not queued.
// Reset clears counters, queue and output; the precision stores are not cleared.
module ranked_list_precision_metrics #(
  parameter int MAX_POSITIVES = 4096,
  parameter int RANK_BITS     = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  rlpm_in_if.sink                              items,
  rlpm_out_if.source                           results,
  input  logic                                 cfg_we,
  input  logic [rlpm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rlpm_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import rlpm_pkg::*;

  localparam int CNT_W = $clog2(MAX_POSITIVES + 1);
  localparam int IDX_W = (MAX_POSITIVES > 1) ? $clog2(MAX_POSITIVES) : 1;
  localparam int CMD_W = 3 + IDX_W + RANK_BITS + CNT_W + 32;

  cfg_t             cfg;
  logic             q_full, q_push, q_pop, q_avail;
  logic [CMD_W-1:0] push_bits, pop_bits;
  logic             take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode  <= MODE_RBP;
      cfg.rate  <= 16'd49152;
      cfg.count <= '0;
      cfg.frac  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:  cfg.mode  <= cfg_data[2:0];
        REG_RATE:  cfg.rate  <= cfg_data[15:0];
        REG_COUNT: cfg.count <= cfg_data[12:0];
        REG_FRAC:  cfg.frac  <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  assign items.ready = !q_full;
  assign take        = items.valid && !q_full;

  rlpm_front #(.MAX_POSITIVES(MAX_POSITIVES), .RANK_BITS(RANK_BITS), .CNT_W(CNT_W),
               .IDX_W(IDX_W), .CMD_W(CMD_W)) u_front (
    .clk, .rst, .take,
    .is_relevant(items.is_relevant), .last_in_list(items.last_in_list),
    .cfg, .push(q_push), .cmd_bits(push_bits)
  );

  rlpm_queue #(.W(CMD_W)) u_queue (
    .clk, .rst, .push(q_push), .push_data(push_bits), .full(q_full),
    .pop(q_pop), .not_empty(q_avail), .pop_data(pop_bits)
  );

  rlpm_back #(.MAX_POSITIVES(MAX_POSITIVES), .RANK_BITS(RANK_BITS), .CNT_W(CNT_W),
              .IDX_W(IDX_W), .CMD_W(CMD_W)) u_back (
    .clk, .rst, .cfg, .cmd_avail(q_avail), .cmd_bits(pop_bits), .cmd_pop(q_pop),
    .res_valid(results.valid), .res_ready(results.ready),
    .result_kind(results.result_kind), .metric_value(results.metric_value),
    .status_code(results.status_code), .last_result(results.last_result)
  );
endmodule

// ----- rtl/rlpm_checker.sv -----
// Port-level checks of the result channel, bound to the top level.
`include "ranked_list_precision_metrics_defines.svh"
module rlpm_checker (
  input logic clk,
  input logic rst,
  input logic valid,
  input logic ready,
  input logic [1:0] result_kind,
  input logic [16:0] metric_value,
  input logic [2:0] status_code,
  input logic last_result
);
  import rlpm_pkg::*;

  `RLPM_ASSERT_SAME(a_point, valid && result_kind == RK_POINT, !last_result && status_code == ST_OK, "precision point malformed")
  `RLPM_ASSERT_SAME(a_end, valid && (result_kind == RK_END || result_kind == RK_FINAL), last_result && (metric_value <= ONE_FX), "list end result malformed")
  `RLPM_ASSERT_NEXT(a_hold, valid && !ready, valid && $stable(metric_value) && $stable(result_kind), "stalled result changed")
  `RLPM_ASSERT_RST(a_rst, rst, !valid, "result valid after reset")
endmodule

bind ranked_list_precision_metrics rlpm_checker u_rlpm_checker (
  .clk(clk), .rst(rst), .valid(results.valid), .ready(results.ready),
  .result_kind(results.result_kind), .metric_value(results.metric_value),
  .status_code(results.status_code), .last_result(results.last_result)
);
